>>> hdl/assert_macros.svh
// assertion helpers shared by the rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property checked on every rising clock edge outside reset
`define ASSERT_CLK(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// expression that must never be true outside reset
`define ASSERT_NEVER(label, clk, rst_n, expr, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) else $error(msg);

`endif

>>> hdl/rht_pkg.sv
package rht_pkg;

  // default sizes of the stores
  localparam int SLOT_COUNT_DEF   = 64;
  localparam int OBJECT_COUNT_DEF = 256;

  // payload widths
  localparam int ACT_W    = 2;
  localparam int HANDLE_W = 16;
  localparam int OBJ_W    = 8;
  localparam int STAT_W   = 2;
  localparam int LIMIT_W  = 7;
  localparam int REF_W    = 8;

  // action codes
  localparam logic [ACT_W-1:0] ACT_INSERT  = 2'd0;
  localparam logic [ACT_W-1:0] ACT_LOOKUP  = 2'd1;
  localparam logic [ACT_W-1:0] ACT_RELEASE = 2'd2;

  // status codes
  localparam logic [STAT_W-1:0] ST_OK      = 2'd0;
  localparam logic [STAT_W-1:0] ST_INVALID = 2'd1;
  localparam logic [STAT_W-1:0] ST_FULL    = 2'd2;

  localparam logic [LIMIT_W-1:0] SLOT_LIMIT_RST = 7'd64;
  localparam logic [REF_W-1:0]   REF_MAX        = 8'hFF;
  localparam logic [1:0]         HANDLE_TAG     = 2'b11;

endpackage

>>> hdl/rht_if.sv
// request channel
interface rht_in_if;
  logic                          valid;
  logic                          ready;
  logic [rht_pkg::ACT_W-1:0]     action;
  logic [rht_pkg::HANDLE_W-1:0]  handle_in;
  logic [rht_pkg::OBJ_W-1:0]     object_in;
  modport source (output valid, action, handle_in, object_in, input ready);
  modport sink (input valid, action, handle_in, object_in, output ready);
endinterface

// result channel
interface rht_out_if;
  logic                          valid;
  logic                          ready;
  logic [rht_pkg::STAT_W-1:0]    status;
  logic [rht_pkg::HANDLE_W-1:0]  handle_out;
  logic [rht_pkg::OBJ_W-1:0]     object_out;
  logic                          object_released;
  modport source (output valid, status, handle_out, object_out, object_released,
                  input ready);
  modport sink (input valid, status, handle_out, object_out, object_released,
                output ready);
endinterface

// configuration write channel
interface rht_cfg_if;
  logic                          valid;
  logic                          ready;
  logic [rht_pkg::LIMIT_W-1:0]   slot_limit;
  modport source (output valid, slot_limit, input ready);
  modport sink (input valid, slot_limit, output ready);
endinterface

>>> hdl/refcounted_handle_table_unit.sv
// Handle table with per-object reference counts. Each request on in_ch (insert,
// lookup, release) gives exactly one transaction on out_ch. Insert, lookup and a
// release that misses load the result register from S_RD1; a release that hits
// loads it from S_RD2, because the reference count address comes out of the slot
// memory read (slot memory read at acceptance, then count memory read, then count
// write-back with the result). A result still waiting on out_ch holds the next
// request in its last stage. Requests are handled one at a time; the next request
// is taken while a finished result still waits on out_ch.
// After reset the count memory is cleared one entry per cycle, through all OBJECT_COUNT
// entries, with in_ch not ready; configuration writes are taken at any time. Valid bits of
// the slots sit in flip-flops and feed a priority encoder that picks the lowest
// free slot below min(slot_limit, SLOT_COUNT) in the accept cycle.
`include "assert_macros.svh"

module refcounted_handle_table_unit #(
  parameter int SLOT_COUNT   = rht_pkg::SLOT_COUNT_DEF,
  parameter int OBJECT_COUNT = rht_pkg::OBJECT_COUNT_DEF
) (
  input  logic         clk,
  input  logic         rst_n,
  rht_in_if.sink       in_ch,
  rht_out_if.source    out_ch,
  rht_cfg_if.sink      cfg_ch
);

  localparam int SIDX_W = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;
  localparam int RIDX_W = $clog2(OBJECT_COUNT);
  localparam int HS_W   = rht_pkg::HANDLE_W - 2;
  localparam int CMP_W  = HS_W + 1;
  localparam int OBJ_N  = 1 << rht_pkg::OBJ_W;

  typedef enum logic [3:0] {
    S_CLEAR = 4'b0001,
    S_IDLE  = 4'b0010,
    S_RD1   = 4'b0100,
    S_RD2   = 4'b1000
  } state_t;

  typedef struct packed {
    logic [rht_pkg::ACT_W-1:0] act;
    logic                      hit;
    logic [SIDX_W-1:0]         slot;
    logic [RIDX_W-1:0]         ridx;
  } req_t;

  state_t                     state_r, state_nxt;
  req_t                       req_r;
  logic [rht_pkg::OBJ_W-1:0]  obj_r;
  logic [SLOT_COUNT-1:0]      slot_valid_r;
  logic [rht_pkg::LIMIT_W-1:0] slot_limit_r;
  logic [RIDX_W-1:0]          clr_idx_r;

  // memories
  logic [rht_pkg::OBJ_W-1:0]  slot_mem [SLOT_COUNT];
  logic [rht_pkg::REF_W-1:0]  refs_mem [OBJECT_COUNT];
  logic [rht_pkg::OBJ_W-1:0]  slot_rdata_r;
  logic [rht_pkg::REF_W-1:0]  ref_rdata_r;

  logic                       out_valid_r;
  logic [rht_pkg::STAT_W-1:0] status_r;
  logic [rht_pkg::HANDLE_W-1:0] handle_r;
  logic [rht_pkg::OBJ_W-1:0]  object_r;
  logic                       released_r;

  // object id to count index, worked out at elaboration
  logic [RIDX_W-1:0] ref_idx_tab [OBJ_N];
  for (genvar g = 0; g < OBJ_N; g++) begin : g_ridx
    assign ref_idx_tab[g] = RIDX_W'(g % OBJECT_COUNT);
  end

  // configuration register
  assign cfg_ch.ready = 1'b1;
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      slot_limit_r <= rht_pkg::SLOT_LIMIT_RST;
    end else if (cfg_ch.valid) begin
      slot_limit_r <= cfg_ch.slot_limit;
    end
  end

  // usable limit
  logic [CMP_W-1:0] lim;
  assign lim = (CMP_W'(slot_limit_r) > CMP_W'(SLOT_COUNT)) ? CMP_W'(SLOT_COUNT)
                                                          : CMP_W'(slot_limit_r);

  // lowest free slot below the limit
  logic              found;
  logic [SIDX_W-1:0] free_slot;
  always_comb begin
    found     = 1'b0;
    free_slot = '0;
    for (int i = SLOT_COUNT - 1; i >= 0; i--) begin
      if (!slot_valid_r[i] && (CMP_W'(i) < lim)) begin
        found     = 1'b1;
        free_slot = SIDX_W'(i);
      end
    end
  end

  // handle decode
  logic [HS_W-1:0]   hs;
  logic [HS_W-1:0]   dec_slot;
  logic [SIDX_W-1:0] dec_idx;
  logic              dec_hit;
  assign hs       = in_ch.handle_in[rht_pkg::HANDLE_W-1:2];
  assign dec_slot = hs - HS_W'(1);
  assign dec_idx  = dec_slot[SIDX_W-1:0];
  assign dec_hit  = (hs != '0) && (CMP_W'(dec_slot) < lim) && slot_valid_r[dec_idx];

  logic accept;
  assign in_ch.ready = (state_r == S_IDLE);
  assign accept      = in_ch.valid && in_ch.ready;

  logic can_load;
  assign can_load = !out_valid_r || out_ch.ready;

  // sequencer and memory port control
  logic                        out_load;
  logic [rht_pkg::STAT_W-1:0]  st_nxt;
  logic [rht_pkg::HANDLE_W-1:0] hout_nxt;
  logic [rht_pkg::OBJ_W-1:0]   oout_nxt;
  logic                        rel_nxt;
  logic                        ref_rd_en, ref_we;
  logic [RIDX_W-1:0]           ref_rd_addr, ref_wr_addr;
  logic [rht_pkg::REF_W-1:0]   ref_wdata;
  logic                        slot_set, slot_clr;

  always_comb begin
    state_nxt   = state_r;
    out_load    = 1'b0;
    st_nxt      = rht_pkg::ST_INVALID;
    hout_nxt    = '0;
    oout_nxt    = '0;
    rel_nxt     = 1'b0;
    ref_rd_en   = 1'b0;
    ref_rd_addr = ref_idx_tab[in_ch.object_in];
    ref_we      = 1'b0;
    ref_wr_addr = req_r.ridx;
    ref_wdata   = '0;
    slot_set    = 1'b0;
    slot_clr    = 1'b0;
    case (state_r)
      S_CLEAR: begin
        ref_we      = 1'b1;
        ref_wr_addr = clr_idx_r;
        if (clr_idx_r == RIDX_W'(OBJECT_COUNT - 1)) begin
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        if (accept) begin
          ref_rd_en = 1'b1;
          slot_set  = (in_ch.action == rht_pkg::ACT_INSERT) && found;
          state_nxt = S_RD1;
        end
      end
      S_RD1: begin
        case (req_r.act)
          rht_pkg::ACT_INSERT: begin
            if (req_r.hit) begin
              st_nxt    = rht_pkg::ST_OK;
              hout_nxt  = {HS_W'(req_r.slot) + HS_W'(1), rht_pkg::HANDLE_TAG};
              ref_we    = can_load;
              ref_wdata = (ref_rdata_r == rht_pkg::REF_MAX) ? ref_rdata_r
                                                            : ref_rdata_r + 8'd1;
            end else begin
              st_nxt = rht_pkg::ST_FULL;
            end
            out_load = can_load;
          end
          rht_pkg::ACT_LOOKUP: begin
            if (req_r.hit) begin
              st_nxt   = rht_pkg::ST_OK;
              oout_nxt = slot_rdata_r;
            end
            out_load = can_load;
          end
          rht_pkg::ACT_RELEASE: begin
            if (req_r.hit) begin
              ref_rd_en   = 1'b1;
              ref_rd_addr = ref_idx_tab[slot_rdata_r];
              slot_clr    = 1'b1;
              state_nxt   = S_RD2;
            end else begin
              out_load = can_load;
            end
          end
          default: begin
            out_load = can_load;
          end
        endcase
        if (out_load) begin
          state_nxt = S_IDLE;
        end
      end
      S_RD2: begin
        st_nxt      = rht_pkg::ST_OK;
        oout_nxt    = obj_r;
        ref_wr_addr = ref_idx_tab[obj_r];
        ref_wdata   = ref_rdata_r - 8'd1;
        ref_we      = can_load && (ref_rdata_r != '0);
        rel_nxt     = (ref_rdata_r == 8'd1);
        out_load    = can_load;
        if (can_load) begin
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_CLEAR;
      clr_idx_r    <= '0;
      slot_valid_r <= '0;
    end else begin
      state_r <= state_nxt;
      if (state_r == S_CLEAR) begin
        clr_idx_r <= clr_idx_r + RIDX_W'(1);
      end
      if (slot_set) begin
        slot_valid_r[free_slot] <= 1'b1;
      end
      if (slot_clr) begin
        slot_valid_r[req_r.slot] <= 1'b0;
      end
    end
  end

  // request register
  always_ff @(posedge clk) begin
    if (accept) begin
      req_r.act  <= in_ch.action;
      req_r.hit  <= (in_ch.action == rht_pkg::ACT_INSERT) ? found : dec_hit;
      req_r.slot <= (in_ch.action == rht_pkg::ACT_INSERT) ? free_slot : dec_idx;
      req_r.ridx <= ref_idx_tab[in_ch.object_in];
    end
    if (slot_clr) begin
      obj_r <= slot_rdata_r;
    end
  end

  // slot object memory
  always_ff @(posedge clk) begin
    if (slot_set) begin
      slot_mem[free_slot] <= in_ch.object_in;
    end
    if (accept) begin
      slot_rdata_r <= slot_mem[dec_idx];
    end
  end

  // reference count memory
  always_ff @(posedge clk) begin
    if (ref_we) begin
      refs_mem[ref_wr_addr] <= ref_wdata;
    end
    if (ref_rd_en) begin
      ref_rdata_r <= refs_mem[ref_rd_addr];
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_load) begin
      out_valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      status_r   <= st_nxt;
      handle_r   <= hout_nxt;
      object_r   <= oout_nxt;
      released_r <= rel_nxt;
    end
  end

  assign out_ch.valid           = out_valid_r;
  assign out_ch.status          = status_r;
  assign out_ch.handle_out      = handle_r;
  assign out_ch.object_out      = object_r;
  assign out_ch.object_released = released_r;

  // checks
  `ASSERT_CLK(a_accept_to_rd1, clk, rst_n, accept |=> (state_r == S_RD1), "accept must start a read")
  `ASSERT_NEVER(a_no_overwrite, clk, rst_n, out_load && out_valid_r && !out_ch.ready, "pending result overwritten")
  `ASSERT_CLK(a_rd2_order, clk, rst_n, (state_r == S_RD2) |-> ($past(state_r) == S_RD1 || $past(state_r) == S_RD2), "count stage out of order")

endmodule

>>> test/testbench.sv
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  import rht_pkg::*;

  localparam int SLOTS = SLOT_COUNT_DEF;
  localparam logic [ACT_W-1:0] ACT_UNDEF = 2'd3;
  localparam int HOLD_OFF_CYCLES = 300;

  // one answer of the table
  typedef struct packed {
    logic [STAT_W-1:0]   status;
    logic [HANDLE_W-1:0] handle;
    logic [OBJ_W-1:0]    obj;
    logic                released;
  } table_answer_t;

  logic clk = 1'b0;
  logic rst_n;

  rht_in_if  in_ch ();
  rht_out_if out_ch ();
  rht_cfg_if cfg_ch ();

  refcounted_handle_table_unit dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch),
    .cfg_ch (cfg_ch)
  );

  // shadow copy of the table
  bit               slot_used [SLOTS];
  logic [OBJ_W-1:0] slot_obj [SLOTS];
  logic [REF_W-1:0] obj_refs [OBJECT_COUNT_DEF];
  logic [LIMIT_W-1:0] cur_limit = SLOT_LIMIT_RST;

  table_answer_t answer_q[$];

  int  fail_count = 0;
  int  hold_cycles = 0;
  bit  no_idle = 1'b0;
  int  n_insert = 0, n_lookup = 0, n_release = 0, n_other = 0;
  int  n_full = 0, n_zero = 0;

  always #1 clk = ~clk;

  // slot index addressed by a handle, -1 when it reaches no valid slot
  function automatic int decode_slot(input logic [HANDLE_W-1:0] h, input int lim);
    int d;
    d = int'(h >> 2);
    if (d == 0) return -1;
    d = d - 1;
    if (d >= lim) return -1;
    if (!slot_used[d]) return -1;
    return d;
  endfunction

  // apply one request to the shadow table and work out its answer
  function automatic table_answer_t predict_answer(input logic [ACT_W-1:0] act,
                                                   input logic [HANDLE_W-1:0] h,
                                                   input logic [OBJ_W-1:0] o);
    table_answer_t r;
    int lim;
    int s;
    logic [OBJ_W-1:0] held;
    r = '{status: ST_INVALID, handle: '0, obj: '0, released: 1'b0};
    lim = (int'(cur_limit) > SLOTS) ? SLOTS : int'(cur_limit);
    case (act)
      ACT_INSERT: begin
        s = 0;
        while (s < lim && slot_used[s]) s++;
        if (s < lim) begin
          slot_used[s] = 1'b1;
          slot_obj[s] = o;
          // count index is the object id itself at this table size
          if (obj_refs[o] != REF_MAX) obj_refs[o] = obj_refs[o] + 1'b1;
          r.status = ST_OK;
          r.handle = HANDLE_W'((s + 1) << 2) | HANDLE_W'(HANDLE_TAG);
        end else begin
          r.status = ST_FULL;
        end
      end
      ACT_LOOKUP: begin
        s = decode_slot(h, lim);
        if (s >= 0) begin
          r.status = ST_OK;
          r.obj = slot_obj[s];
        end
      end
      ACT_RELEASE: begin
        s = decode_slot(h, lim);
        if (s >= 0) begin
          held = slot_obj[s];
          if (obj_refs[held] != '0) begin
            obj_refs[held] = obj_refs[held] - 1'b1;
            if (obj_refs[held] == '0) r.released = 1'b1;
          end
          slot_used[s] = 1'b0;
          slot_obj[s] = '0;
          r.status = ST_OK;
          r.obj = held;
        end
      end
      default: ;
    endcase
    return r;
  endfunction

  // one request transaction, with an optional gap in front
  task automatic send_request(input logic [ACT_W-1:0] act, input logic [HANDLE_W-1:0] h,
                              input logic [OBJ_W-1:0] o);
    if (!no_idle && $urandom_range(99) < 15) begin
      in_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(negedge clk);
    end
    in_ch.valid     <= 1'b1;
    in_ch.action    <= act;
    in_ch.handle_in <= h;
    in_ch.object_in <= o;
    do @(posedge clk); while (!in_ch.ready);
    answer_q.push_back(predict_answer(act, h, o));
    case (act)
      ACT_INSERT:  n_insert++;
      ACT_LOOKUP:  n_lookup++;
      ACT_RELEASE: n_release++;
      default:     n_other++;
    endcase
    @(negedge clk);
  endtask

  // register write once the table has answered everything
  task automatic write_slot_limit(input logic [LIMIT_W-1:0] value);
    in_ch.valid <= 1'b0;
    while (answer_q.size() != 0) @(negedge clk);
    cfg_ch.valid      <= 1'b1;
    cfg_ch.slot_limit <= value;
    do @(posedge clk); while (!cfg_ch.ready);
    cur_limit = value;
    @(negedge clk);
    cfg_ch.valid <= 1'b0;
  endtask

  // mostly well-formed traffic on live handles, some noise
  task automatic random_request();
    int pick;
    int live[$];
    logic [ACT_W-1:0] act;
    logic [HANDLE_W-1:0] h;
    logic [OBJ_W-1:0] o;
    pick = $urandom_range(99);
    h = HANDLE_W'($urandom);
    // a small pool of objects so that counts climb above one
    if ($urandom_range(99) < 70) o = OBJ_W'($urandom_range(7) * 37);
    else o = OBJ_W'($urandom);
    for (int s = 0; s < SLOTS; s++) if (slot_used[s]) live.push_back(s);
    if (pick < 45) begin
      act = ACT_INSERT;
    end else if (pick < 90) begin
      act = (pick < 70) ? ACT_LOOKUP : ACT_RELEASE;
      if (live.size() > 0)
        h = HANDLE_W'((live[$urandom_range(live.size() - 1)] + 1) << 2) |
            HANDLE_W'($urandom_range(3));
    end else begin
      act = ACT_W'($urandom_range(3));
    end
    send_request(act, h, o);
  endtask

  // result side: random stalls, long hold-off on request
  initial begin
    out_ch.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_cycles > 0) begin
        hold_cycles--;
        out_ch.ready <= 1'b0;
      end else if (no_idle) begin
        out_ch.ready <= 1'b1;
      end else begin
        out_ch.ready <= ($urandom_range(99) >= 15);
      end
    end
  end

  // compare each result transaction with the oldest prediction
  always @(posedge clk) begin
    table_answer_t exp_a;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (answer_q.size() == 0) begin
        $error("result with no request outstanding: status %0d", out_ch.status);
        fail_count++;
      end else begin
        exp_a = answer_q.pop_front();
        if (exp_a.status == ST_FULL) n_full++;
        if (exp_a.released) n_zero++;
        if (out_ch.status !== exp_a.status) begin
          $error("status: expected %0d, got %0d", exp_a.status, out_ch.status);
          fail_count++;
        end
        if (out_ch.handle_out !== exp_a.handle) begin
          $error("handle_out: expected %h, got %h", exp_a.handle, out_ch.handle_out);
          fail_count++;
        end
        if (out_ch.object_out !== exp_a.obj) begin
          $error("object_out: expected %h, got %h", exp_a.obj, out_ch.object_out);
          fail_count++;
        end
        if (out_ch.object_released !== exp_a.released) begin
          $error("object_released: expected %0d, got %0d", exp_a.released,
                 out_ch.object_released);
          fail_count++;
        end
      end
    end
  end

  // insert at both object extremes, lookups with varied tag bits
  task automatic test_insert_lookup();
    send_request(ACT_INSERT, 16'h0000, 8'h00);
    send_request(ACT_INSERT, 16'hFFFF, 8'hFF);
    send_request(ACT_INSERT, 16'h0000, 8'h00);
    send_request(ACT_LOOKUP, 16'h0007, 8'h00);
    send_request(ACT_LOOKUP, 16'h0008, 8'hFF);
  endtask

  // handles below four, far out of range, empty slots, undefined action
  task automatic test_bad_handles();
    send_request(ACT_LOOKUP, 16'h0000, 8'h00);
    send_request(ACT_RELEASE, 16'h0003, 8'h00);
    send_request(ACT_LOOKUP, 16'hFFFF, 8'h00);
    send_request(ACT_LOOKUP, 16'h002C, 8'h00);
    send_request(ACT_RELEASE, 16'h002F, 8'h00);
    send_request(ACT_UNDEF, 16'h0007, 8'hAA);
  endtask

  // count drops, double release, lowest free slot reused
  task automatic test_release_counts();
    send_request(ACT_RELEASE, 16'h0007, 8'h00);
    send_request(ACT_RELEASE, 16'h0004, 8'h00);
    send_request(ACT_RELEASE, 16'h000F, 8'h00);
    send_request(ACT_RELEASE, 16'h000B, 8'h00);
    send_request(ACT_INSERT, 16'h0000, 8'h5A);
  endtask

  // zero limit, limit above the table, lowered then raised limit
  task automatic test_limit_settings();
    write_slot_limit(7'd0);
    send_request(ACT_INSERT, 16'h0000, 8'h11);
    send_request(ACT_LOOKUP, 16'h0007, 8'h00);
    write_slot_limit(7'd127);
    send_request(ACT_INSERT, 16'h0000, 8'h22);
    send_request(ACT_LOOKUP, 16'h0007, 8'h00);
    write_slot_limit(7'd1);
    send_request(ACT_INSERT, 16'h0000, 8'h33);
    send_request(ACT_LOOKUP, 16'h000B, 8'h00);
    write_slot_limit(SLOT_LIMIT_RST);
    send_request(ACT_LOOKUP, 16'h000B, 8'h00);
  endtask

  task automatic test_random_traffic(input logic [LIMIT_W-1:0] limit, input int count);
    write_slot_limit(limit);
    repeat (count) random_request();
  endtask

  // back-to-back traffic with both sides always willing
  task automatic test_quiet_stretch(input int count);
    no_idle = 1'b1;
    repeat (count) random_request();
    no_idle = 1'b0;
  endtask

  // receiver holds off while requests keep coming, so the input stalls
  task automatic test_backpressure(input int count);
    in_ch.valid <= 1'b0;
    @(posedge clk);
    hold_cycles = HOLD_OFF_CYCLES;
    @(negedge clk);
    no_idle = 1'b1;
    repeat (count) random_request();
    no_idle = 1'b0;
  endtask

  initial begin
    rst_n = 1'b0;
    in_ch.valid = 1'b0;
    in_ch.action = ACT_INSERT;
    in_ch.handle_in = '0;
    in_ch.object_in = '0;
    cfg_ch.valid = 1'b0;
    cfg_ch.slot_limit = SLOT_LIMIT_RST;
    for (int i = 0; i < SLOTS; i++) begin
      slot_used[i] = 1'b0;
      slot_obj[i] = '0;
    end
    for (int i = 0; i < OBJECT_COUNT_DEF; i++) obj_refs[i] = '0;
    repeat (5) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    test_insert_lookup();
    test_bad_handles();
    test_release_counts();
    test_limit_settings();

    test_random_traffic(SLOT_LIMIT_RST, 300);
    test_random_traffic(7'd2, 120);
    test_random_traffic(7'd127, 250);
    test_random_traffic(7'd0, 40);
    test_random_traffic(LIMIT_W'($urandom_range(3, 63)), 280);
    write_slot_limit(SLOT_LIMIT_RST);
    test_quiet_stretch(200);
    test_backpressure(40);
    test_random_traffic(LIMIT_W'($urandom_range(1, 64)), 120);

    // drain and let the block settle
    in_ch.valid <= 1'b0;
    while (answer_q.size() != 0) @(negedge clk);
    repeat (10) @(negedge clk);
    $display("requests: %0d insert, %0d lookup, %0d release, %0d undefined action",
             n_insert, n_lookup, n_release, n_other);
    $display("table full answers: %0d, counts dropped to zero: %0d", n_full, n_zero);
    if (fail_count == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

  // watchdog
  initial begin
    #500000;
    $display("*** FAILED ***");
    $finish;
  end

endmodule
